@@ src/jse_pkg.sv @@
`timescale 1ns / 1ps

package jse_pkg;

    localparam int unsigned MaxBeats = 15;

    localparam logic [7:0] ChQuote     = 8'h22;
    localparam logic [7:0] ChBackslash = 8'h5C;
    localparam logic [7:0] ChLowerU    = 8'h75;
    localparam logic [7:0] ChZero      = 8'h30;

    localparam logic [95:0] FffdRep = {4{8'hBD, 8'hBF, 8'hEF}};

    localparam logic [20:0] CpMax      = 21'h10FFFF;
    localparam logic [20:0] CpSurrLo   = 21'h00D800;
    localparam logic [20:0] CpSurrHi   = 21'h00DFFF;
    localparam logic [20:0] CpMin2     = 21'h000080;
    localparam logic [20:0] CpMin3     = 21'h000800;
    localparam logic [20:0] CpMin4     = 21'h010000;

    typedef struct packed {
        logic [MaxBeats-1:0][7:0] bytes;
        logic [3:0]               count;
    } burst_t;

    typedef struct packed {
        logic [5:0][7:0] tail;
        logic [2:0]      len;
        logic            lead;
        logic [2:0]      slen;
        logic [20:0]     acc0;
    } fresh_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10) begin
            r = 8'h30 + {4'd0, nib};
        end else begin
            r = 8'h57 + {4'd0, nib};
        end
        return r;
    endfunction

    function automatic fresh_t fresh_esc(input logic [7:0] c);
        fresh_t     f;
        logic [7:0] esc;
        f = '0;
        case (c)
            8'h22:   esc = 8'h22;
            8'h5C:   esc = 8'h5C;
            8'h08:   esc = 8'h62;
            8'h0C:   esc = 8'h66;
            8'h0A:   esc = 8'h6E;
            8'h0D:   esc = 8'h72;
            8'h09:   esc = 8'h74;
            default: esc = 8'h00;
        endcase
        if (esc != 8'h00) begin
            f.tail[0] = ChBackslash;
            f.tail[1] = esc;
            f.len     = 3'd2;
        end else if (c < 8'h20) begin
            f.tail[0] = ChBackslash;
            f.tail[1] = ChLowerU;
            f.tail[2] = ChZero;
            f.tail[3] = ChZero;
            f.tail[4] = hex_digit(c[7:4]);
            f.tail[5] = hex_digit(c[3:0]);
            f.len     = 3'd6;
        end else if (c < 8'h80) begin
            f.tail[0] = c;
            f.len     = 3'd1;
        end else if (c[7:5] == 3'b110) begin
            f.lead = 1'b1;
            f.slen = 3'd2;
            f.acc0 = {16'd0, c[4:0]};
        end else if (c[7:4] == 4'b1110) begin
            f.lead = 1'b1;
            f.slen = 3'd3;
            f.acc0 = {17'd0, c[3:0]};
        end else if (c[7:3] == 5'b11110) begin
            f.lead = 1'b1;
            f.slen = 3'd4;
            f.acc0 = {18'd0, c[2:0]};
        end else begin
            f.tail[0] = 8'hEF;
            f.tail[1] = 8'hBF;
            f.tail[2] = 8'hBD;
            f.len     = 3'd3;
        end
        return f;
    endfunction

endpackage

@@ src/jse_encode.sv @@
`timescale 1ns / 1ps

module jse_encode (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  logic              kind,
    input  logic [7:0]        data_byte,
    output jse_pkg::burst_t   burst
);

    logic            quote_opened_reg, quote_opened_next;
    logic [1:0]      pend_cnt_reg, pend_cnt_next;
    logic [2:0]      seq_len_reg, seq_len_next;
    logic [20:0]     acc_reg, acc_next;
    logic [2:0][7:0] pend_bytes_reg;
    logic            pb_we;
    logic [1:0]      pb_idx;

    jse_pkg::fresh_t fr;
    logic            qn;
    logic [2:0]      k;
    logic [5:0][7:0] tail;
    logic [2:0]      tlen;
    logic [3:0][7:0] pass;
    logic [20:0]     acc_cat;
    logic            is_cont;
    logic            ok;
    logic [3:0]      k3;
    logic [95:0]     fffd_mask;
    logic [127:0]    all_bytes;
    logic [4:0]      total;

    always_comb begin
        fr       = jse_pkg::fresh_esc(data_byte);
        qn       = !quote_opened_reg;
        acc_cat  = {acc_reg[14:0], data_byte[5:0]};
        is_cont  = (data_byte[7:6] == 2'b10);
        k        = 3'd0;
        tail     = '0;
        tlen     = 3'd0;
        pb_we    = 1'b0;
        pb_idx   = pend_cnt_reg;

        quote_opened_next = !kind;
        pend_cnt_next     = pend_cnt_reg;
        seq_len_next      = seq_len_reg;
        acc_next          = acc_reg;

        pass[0] = (pend_cnt_reg > 2'd0) ? pend_bytes_reg[0] : data_byte;
        pass[1] = (pend_cnt_reg > 2'd1) ? pend_bytes_reg[1] :
                  ((pend_cnt_reg == 2'd1) ? data_byte : 8'h00);
        pass[2] = (pend_cnt_reg > 2'd2) ? pend_bytes_reg[2] :
                  ((pend_cnt_reg == 2'd2) ? data_byte : 8'h00);
        pass[3] = (pend_cnt_reg == 2'd3) ? data_byte : 8'h00;

        ok = 1'b1;
        if (seq_len_reg == 3'd2 && acc_cat < jse_pkg::CpMin2) ok = 1'b0;
        if (seq_len_reg == 3'd3 && acc_cat < jse_pkg::CpMin3) ok = 1'b0;
        if (seq_len_reg == 3'd4 && acc_cat < jse_pkg::CpMin4) ok = 1'b0;
        if (acc_cat > jse_pkg::CpMax) ok = 1'b0;
        if (acc_cat >= jse_pkg::CpSurrLo && acc_cat <= jse_pkg::CpSurrHi) ok = 1'b0;

        if (kind) begin
            k             = {1'b0, pend_cnt_reg};
            tail[0]       = jse_pkg::ChQuote;
            tlen          = 3'd1;
            pend_cnt_next = 2'd0;
            seq_len_next  = 3'd0;
            acc_next      = '0;
        end else if (pend_cnt_reg == 2'd0 || !is_cont) begin
            k    = {1'b0, pend_cnt_reg};
            tail = fr.tail;
            tlen = fr.len;
            if (fr.lead) begin
                pend_cnt_next = 2'd1;
                seq_len_next  = fr.slen;
                acc_next      = fr.acc0;
                pb_we         = 1'b1;
                pb_idx        = 2'd0;
            end else begin
                pend_cnt_next = 2'd0;
                seq_len_next  = 3'd0;
                acc_next      = '0;
            end
        end else if (({1'b0, pend_cnt_reg} + 3'd1) < seq_len_reg && pend_cnt_reg < 2'd3) begin
            pend_cnt_next = pend_cnt_reg + 2'd1;
            acc_next      = acc_cat;
            pb_we         = 1'b1;
        end else begin
            if (ok) begin
                tail = {16'd0, pass};
                tlen = {1'b0, pend_cnt_reg} + 3'd1;
            end else begin
                k = {1'b0, pend_cnt_reg} + 3'd1;
            end
            pend_cnt_next = 2'd0;
            seq_len_next  = 3'd0;
            acc_next      = '0;
        end

        k3        = {k, 1'b0} + {1'b0, k};
        fffd_mask = (96'd1 << {k3, 3'b000}) - 96'd1;
        all_bytes = (qn ? {120'd0, jse_pkg::ChQuote} : 128'd0)
                  | ({32'd0, jse_pkg::FffdRep & fffd_mask} << {3'd0, qn, 3'b000})
                  | ({80'd0, tail} << {k3 + {3'd0, qn}, 3'b000});
        total     = {4'd0, qn} + {1'b0, k3} + {2'd0, tlen};

        burst.bytes = all_bytes[119:0];
        burst.count = (total > 5'd15) ? 4'd15 : total[3:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quote_opened_reg <= 1'b0;
            pend_cnt_reg     <= 2'd0;
            seq_len_reg      <= 3'd0;
            acc_reg          <= '0;
        end else if (fire) begin
            quote_opened_reg <= quote_opened_next;
            pend_cnt_reg     <= pend_cnt_next;
            seq_len_reg      <= seq_len_next;
            acc_reg          <= acc_next;
        end
    end

    // held lead and continuation bytes, no reset needed
    always_ff @(posedge aclk) begin
        if (fire && pb_we && !kind) begin
            pend_bytes_reg[pb_idx] <= data_byte;
        end
    end

endmodule

@@ src/jse_serializer.sv @@
`timescale 1ns / 1ps

module jse_serializer (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            load,
    input  jse_pkg::burst_t burst,
    output logic            free,
    output logic [7:0]      m_tdata,   // out_byte[7:0]
    output logic            m_tlast,
    output logic            m_tvalid,
    input  logic            m_tready
);

    logic [jse_pkg::MaxBeats-1:0][7:0] buf_reg;
    logic [3:0]                        rem_reg;
    logic                              beat;

    assign m_tvalid = (rem_reg != 4'd0);
    assign m_tdata  = buf_reg[0];
    assign m_tlast  = (rem_reg == 4'd1);
    assign beat     = m_tvalid && m_tready;
    assign free     = (rem_reg == 4'd0) || (rem_reg == 4'd1 && m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= 4'd0;
        end else if (load) begin
            rem_reg <= burst.count;
        end else if (beat) begin
            rem_reg <= rem_reg - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            buf_reg <= burst.bytes;
        end else if (beat) begin
            buf_reg <= {8'h00, buf_reg[jse_pkg::MaxBeats-1:1]};
        end
    end

endmodule

@@ src/json_string_escaper.sv @@
`timescale 1ns / 1ps
// an input beat is registered, then encoded and loaded into the serializer,
// which sends its 0 to 15 output beats, one escaped byte per cycle while
// m_tready is high; the next item waits in the input stage meanwhile
// reset: synchronous active-low aresetn clears the input stage, the held
// utf-8 sequence, the quote state and any output beats still queued

module json_string_escaper (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] s_tdata,   // data_byte[7:0]
    input  logic       s_tuser,   // kind
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic [7:0] m_tdata,   // out_byte[7:0]
    output logic       m_tlast,
    output logic       m_tvalid,
    input  logic       m_tready
);

    logic            in_valid_reg;
    logic            kind_reg;
    logic [7:0]      byte_reg;
    logic            free;
    logic            advance;
    jse_pkg::burst_t burst;

    assign advance  = in_valid_reg && free;
    assign s_tready = !in_valid_reg || free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            kind_reg <= s_tuser;
            byte_reg <= s_tdata;
        end
    end

    jse_encode u_encode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (advance),
        .kind      (kind_reg),
        .data_byte (byte_reg),
        .burst     (burst)
    );

    jse_serializer u_serializer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .burst    (burst),
        .free     (free),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

endmodule

@@ src/jse_checker.sv @@
`timescale 1ns / 1ps

module jse_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       m_tvalid,
    input logic       m_tready
);

    logic [3:0] beat_cnt_reg;
    logic       m_beat;

    assign m_beat = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_cnt_reg <= 4'd0;
        end else if (m_beat) begin
            beat_cnt_reg <= m_tlast ? 4'd0 : beat_cnt_reg + 4'd1;
        end
    end

    // a stalled output beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    // no more than fifteen beats per item
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_beat && !m_tlast |-> beat_cnt_reg < 4'd14)
        else $error("burst longer than fifteen beats");

    // reset empties the output side
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // reset leaves the input side open
    assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready right after reset");

    // input stays open while no output is pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && !$past(s_tvalid && s_tready) |-> s_tready)
        else $error("input stalled with nothing pending");

endmodule

bind json_string_escaper jse_checker u_jse_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
